// ----- design/base64_mime_line_encoder_defines.svh -----
// Assertion macros used by b64ml_back of the base64 MIME line encoder RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef BASE64_MIME_LINE_ENCODER_DEFINES_SVH
`define BASE64_MIME_LINE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define B64ML_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define B64ML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/b64ml_pkg.sv -----
// Package for the base64 MIME line encoder: item types, group entry type,
// character constants and the base64 alphabet function. No dependencies.
package b64ml_pkg;

	localparam int LINE_CHARS_DEF = 76;
	localparam int COL_W          = 7;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_item_t;

	// One finished group as handed from front to back
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  taken;
		logic        crlf;
		logic        fin;
	} grp_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] v8;
		v8 = {2'b00, v};
		if (v < 6'd26)
			return 8'(8'd65 + v8);
		else if (v < 6'd52)
			return 8'(8'd97 + v8 - 8'd26);
		else if (v < 6'd62)
			return 8'(8'd48 + v8 - 8'd52);
		else if (v == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

endpackage

// ----- design/b64ml_front.sv -----
// Front of the base64 MIME line encoder: gathers bytes into groups and
// tracks the line column. Depends on b64ml_pkg.
module b64ml_front #(
	parameter int LINE_CHARS = b64ml_pkg::LINE_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64ml_pkg::in_item_t byte_data,
	output logic                push,
	output b64ml_pkg::grp_t     push_grp,
	input  logic                queue_full
);

	logic [15:0]                  held_q;
	logic [1:0]                   pos_q;
	logic [b64ml_pkg::COL_W-1:0]  col_q;
	logic [b64ml_pkg::COL_W-1:0]  col_next;
	logic [1:0]                   pos;
	logic                         accept;
	logic                         close;
	logic                         crlf;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;
	assign pos        = (pos_q == 2'd3) ? 2'd0 : pos_q;
	assign close      = byte_data.final_byte || (pos == 2'd2);
	assign col_next   = b64ml_pkg::COL_W'(col_q + b64ml_pkg::COL_W'(4));
	assign crlf       = col_next >= b64ml_pkg::COL_W'(LINE_CHARS);
	assign push       = accept && close;

	always_comb begin
		push_grp       = '0;
		push_grp.taken = 2'(pos + 2'd1);
		push_grp.crlf  = crlf;
		push_grp.fin   = byte_data.final_byte;
		unique case (pos)
			2'd0:    push_grp.word = {byte_data.in_byte, 16'h0000};
			2'd1:    push_grp.word = {held_q[15:8], byte_data.in_byte, 8'h00};
			default: push_grp.word = {held_q, byte_data.in_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (close) begin
				held_q <= '0;
				pos_q  <= '0;
				col_q  <= (crlf || byte_data.final_byte) ? '0 : col_next;
			end else begin
				if (pos == 2'd0)
					held_q <= {byte_data.in_byte, 8'h00};
				else
					held_q <= {held_q[15:8], byte_data.in_byte};
				pos_q <= 2'(pos + 2'd1);
			end
		end
	end

endmodule

// ----- design/b64ml_queue.sv -----
// Short queue of finished groups between front and back of the encoder.
// Depends on b64ml_pkg.
module b64ml_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64ml_pkg::grp_t push_grp,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output b64ml_pkg::grp_t head_grp
);

	localparam int DEPTH = b64ml_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64ml_pkg::grp_t   ent_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_grp   = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

endmodule

// ----- design/b64ml_back.sv -----
// Back of the base64 MIME line encoder: turns one queued group into four
// characters plus optional CR LF, one per unstalled cycle; needs b64ml_pkg.
`include "base64_mime_line_encoder_defines.svh"

module b64ml_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  b64ml_pkg::grp_t      head_grp,
	output logic                 pop,
	output logic                 char_valid,
	input  logic                 char_stall,
	output b64ml_pkg::out_item_t char_data
);

	localparam logic [2:0] SLOT_DATA_LAST = 3'd3;
	localparam logic [2:0] SLOT_CR        = 3'd4;
	localparam logic [2:0] SLOT_LF        = 3'd5;

	logic [2:0]           slot_q;
	logic [2:0]           last_slot;
	logic                 load;
	logic                 at_last;
	logic [5:0]           sextet;
	logic [7:0]           ch;
	logic                 valid_q;
	b64ml_pkg::out_item_t out_q;

	assign load      = head_valid && (!valid_q || !char_stall);
	assign last_slot = head_grp.crlf ? SLOT_LF : SLOT_DATA_LAST;
	assign at_last   = slot_q == last_slot;
	assign pop       = load && at_last;

	always_comb begin
		sextet = '0;
		ch     = b64ml_pkg::CHAR_CR;
		unique case (slot_q)
			3'd0:    sextet = head_grp.word[23:18];
			3'd1:    sextet = head_grp.word[17:12];
			3'd2:    sextet = head_grp.word[11:6];
			3'd3:    sextet = head_grp.word[5:0];
			default: sextet = '0;
		endcase
		if (slot_q == SLOT_CR)
			ch = b64ml_pkg::CHAR_CR;
		else if (slot_q == SLOT_LF)
			ch = b64ml_pkg::CHAR_LF;
		else if (slot_q[1:0] > head_grp.taken)
			ch = b64ml_pkg::CHAR_PAD;
		else
			ch = b64ml_pkg::b64_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			slot_q  <= at_last ? 3'd0 : 3'(slot_q + 3'd1);
		end else if (!char_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char <= ch;
			out_q.out_last <= head_grp.fin && at_last;
		end
	end

	assign char_valid = valid_q;
	assign char_data  = out_q;

	`B64ML_ASSERT_NOW(a_slot_range, 1'b1, slot_q <= SLOT_LF, "slot counter out of range")
	`B64ML_ASSERT_NOW(a_mid_group_head, slot_q != 3'd0, head_valid, "group lost mid-emission")
	`B64ML_ASSERT_NOW(a_pop_at_last, pop, load && slot_q == last_slot, "pop off the last slot")
	`B64ML_ASSERT_NEXT(a_last_from_fin, load && head_grp.fin && at_last,
		char_valid && char_data.out_last, "final character not marked")

endmodule

// ----- design/base64_mime_line_encoder.sv -----
// Base64 MIME encoder: bytes in, base64 characters out, CR LF after each
// LINE_CHARS-wide line, after the final group only if it ends a line; a
// group passes a 4-entry queue and the back's output register. The back
// emits one character per unstalled cycle (4 or 6 per group); the front
// takes one byte per cycle until the queue fills. arst_n clears all control.
module base64_mime_line_encoder #(
	parameter int LINE_CHARS = b64ml_pkg::LINE_CHARS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  b64ml_pkg::in_item_t  byte_data,
	output logic                 char_valid,
	input  logic                 char_stall,
	output b64ml_pkg::out_item_t char_data
);

	logic            push;
	b64ml_pkg::grp_t push_grp;
	logic            queue_full;
	logic            pop;
	logic            head_valid;
	b64ml_pkg::grp_t head_grp;

	b64ml_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.push       (push),
		.push_grp   (push_grp),
		.queue_full (queue_full)
	);

	b64ml_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (push_grp),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_grp   (head_grp)
	);

	b64ml_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_grp   (head_grp),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

// ----- verif/tb_base64_mime_line_encoder.sv -----
// Self-checking testbench for base64_mime_line_encoder: byte messages in,
// base64 characters with CR LF line breaks out. Depends on b64ml_pkg and the DUT.
module tb_base64_mime_line_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    LINE_LIMIT   = b64ml_pkg::LINE_CHARS_DEF;
	localparam int    RANDOM_BYTES = 360;
	localparam int    DRAIN_CYCLES = 16;
	localparam int    IDLE_LIMIT   = 3000;
	localparam string B64_SYMBOLS  =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Tracks the encoder state and holds the characters still owed by it
	class mime_char_tracker;
		logic [15:0]          held;
		logic [1:0]           grp_pos;
		logic [6:0]           line_col;
		b64ml_pkg::out_item_t expected_chars[$];
		int                   mismatches;

		function new();
			held = '0;
			grp_pos = '0;
			line_col = '0;
			mismatches = 0;
		endfunction

		function void take_byte(input b64ml_pkg::in_item_t it);
			logic [23:0]          word;
			int                   taken;
			b64ml_pkg::out_item_t c;
			if (!it.final_byte && grp_pos < 2) begin
				if (grp_pos == 0)
					held = {it.in_byte, 8'h00};
				else
					held[7:0] = it.in_byte;
				grp_pos = grp_pos + 2'd1;
				return;
			end
			case (grp_pos)
				2'd0: word = {it.in_byte, 16'h0000};
				2'd1: word = {held[15:8], it.in_byte, 8'h00};
				default: word = {held, it.in_byte};
			endcase
			taken = int'(grp_pos) + 1;
			for (int i = 0; i < 4; i++) begin
				c.out_char = (i > taken) ? b64ml_pkg::CHAR_PAD
					: B64_SYMBOLS[word[23 - 6 * i -: 6]];
				c.out_last = 1'b0;
				expected_chars.push_back(c);
			end
			line_col = line_col + 7'd4;
			if (line_col >= LINE_LIMIT) begin
				c.out_char = b64ml_pkg::CHAR_CR;
				expected_chars.push_back(c);
				c.out_char = b64ml_pkg::CHAR_LF;
				expected_chars.push_back(c);
				line_col = '0;
			end
			held = '0;
			grp_pos = '0;
			if (it.final_byte) begin
				expected_chars[$].out_last = 1'b1;
				line_col = '0;
			end
		endfunction

		function void check_char(input b64ml_pkg::out_item_t got);
			b64ml_pkg::out_item_t want;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char %h last %b", $time, got.out_char, got.out_last);
				mismatches++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char) begin
				$display("%0t: out_char expected %h actual %h", $time, want.out_char,
					got.out_char);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$display("%0t: out_last expected %b actual %b", $time, want.out_last,
					got.out_last);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	b64ml_pkg::in_item_t  byte_data;
	logic                 char_valid;
	logic                 char_stall;
	b64ml_pkg::out_item_t char_data;

	mime_char_tracker tracker;
	int               bytes_sent;
	bit               sender_quiet;
	int               idle_cycles = 0;
	logic [7:0]       msg[$];

	base64_mime_line_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Present one item at a falling edge and hold it until taken
	task automatic send_byte(input b64ml_pkg::in_item_t it);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid = 1'b1;
		byte_data = it;
		do
			@(posedge clk);
		while (byte_stall);
		tracker.take_byte(it);
		bytes_sent++;
	endtask

	task automatic send_message(input logic [7:0] bytes[$]);
		b64ml_pkg::in_item_t it;
		for (int i = 0; i < bytes.size(); i++) begin
			it.in_byte = bytes[i];
			it.final_byte = (i == bytes.size() - 1);
			send_byte(it);
		end
	endtask

	task automatic send_random_message();
		int len;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = ($urandom_range(0, 1) == 0) ? 57 : 114;  // end exactly on a line break
		else if (pick < 3)
			len = $urandom_range(40, 130);
		else
			len = $urandom_range(1, 10);
		// Trim the last message to the byte budget
		if (len > RANDOM_BYTES - bytes_sent)
			len = RANDOM_BYTES - bytes_sent;
		msg.delete();
		repeat (len) msg.push_back(8'($urandom_range(0, 255)));
		sender_quiet = ($urandom_range(0, 3) == 0);
		send_message(msg);
	endtask

	// Receiver backpressure; in every third stretch of cycles no new stall starts
	initial begin
		int stall_left;
		int cyc;
		stall_left = 0;
		cyc = 0;
		char_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (stall_left > 0) begin
				char_stall = 1'b1;
				stall_left--;
			end else begin
				char_stall = 1'b0;
				if ((cyc / 400) % 3 != 0 && $urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			tracker.check_char(char_data);
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_base64_mime_line_encoder: errors");
			$finish;
		end
	end

	initial begin
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		bytes_sent = 0;
		sender_quiet = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Short messages: each pad case, alphabet extremes, all-zero and all-one bytes
		msg = '{8'h00};
		send_message(msg);
		msg = '{8'hFF};
		send_message(msg);
		msg = '{8'h00, 8'hFF};
		send_message(msg);
		msg = '{8'hFB, 8'hFF, 8'hBF};
		send_message(msg);
		msg = '{8'h00, 8'h00, 8'h00};
		send_message(msg);
		msg = '{8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01};
		send_message(msg);
		msg = '{8'h4D, 8'h61, 8'h6E, 8'h14};
		send_message(msg);

		while (bytes_sent < RANDOM_BYTES)
			send_random_message();
		@(negedge clk);
		byte_valid = 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("tb_base64_mime_line_encoder: clean");
		else
			$display("tb_base64_mime_line_encoder: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/b64ml_pkg.sv
design/b64ml_front.sv
design/b64ml_queue.sv
design/b64ml_back.sv
design/base64_mime_line_encoder.sv
verif/tb_base64_mime_line_encoder.sv
